// ----- rtl/lts_pkg.sv -----
// lottery thread scheduler: shared constants, codes and sequencer states
// no dependencies
package lts_pkg;

  localparam int THREADS_DEF     = 8;
  localparam int TICKET_BITS_DEF = 16;

  localparam int CFG_W      = 4;
  localparam int TIDX_W     = 3;
  localparam int TCOUNT_W   = 16;
  localparam int RAND_W     = 32;
  localparam int PROG_W     = 7;

  localparam logic [PROG_W-1:0] PROGRESS_STEP = 7'd20;
  localparam logic [PROG_W-1:0] PROGRESS_DONE = 7'd100;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESULT
  } state_t;

endpackage

// ----- rtl/lts_ram.sv -----
// generic single-clock ram, one write port and one read port
// read data registered, no dependencies
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lts_mod.sv -----
// iterative remainder unit: 32-bit word modulo the ticket total
// one quotient bit per cycle, uses lts_pkg
module lts_mod
  import lts_pkg::*;
#(
  parameter int SUM_W = TICKET_BITS_DEF + 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [SUM_W-1:0]  divisor,
  output logic              done,
  output logic [SUM_W-1:0]  rem
);

  localparam int CNT_W = $clog2(RAND_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] dq;
  logic [SUM_W-1:0]  dvs;
  logic [SUM_W:0]    shifted;
  logic [SUM_W:0]    diff;
  logic [SUM_W-1:0]  rem_next;

  always_comb begin
    shifted = {rem, dq[RAND_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (shifted >= {1'b0, dvs}) begin
      rem_next = diff[SUM_W-1:0];
    end else begin
      rem_next = shifted[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      dq  <= dividend;
      dvs <= divisor;
      rem <= '0;
      cnt <= CNT_W'(RAND_W - 1);
    end else if (busy) begin
      dq  <= {dq[RAND_W-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ----- rtl/lottery_thread_scheduler_top.sv -----
// lottery thread scheduler top: ticket/progress ram, draw sequencer, result register
// uses lts_pkg, lts_ram, lts_mod
//
//   channel   signals                                              dir
//   input     in_valid in_stall kind thread_index ticket_count      in
//             random_value
//   result    out_valid out_stall winner_index winner_progress      out
//             winner_finished all_finished none_eligible
//   config    cfg_wr_en cfg_wr_data                                 in
//
// load beat: ram write in ST_IDLE, then ST_RESULT loads the result register
// draw beat: ticket sum over n active threads (ST_SUM_RD, ST_SUM_ACC), remainder
//   unit (ST_DIV), winner scan to winner index w (ST_SCAN_RD/CHK), then ST_RESULT
// one item at a time, the ram port is walked twice per draw
// rst clears ram valid bits, so the tables read as zero until written
// a stalled result holds in the output register while the next beat is taken
module lottery_thread_scheduler_top
  import lts_pkg::*;
#(
  parameter int THREADS     = THREADS_DEF,
  parameter int TICKET_BITS = TICKET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [TIDX_W-1:0]   thread_index,
  input  logic [TCOUNT_W-1:0] ticket_count,
  input  logic [RAND_W-1:0]   random_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TIDX_W-1:0]   winner_index,
  output logic [PROG_W-1:0]   winner_progress,
  output logic                winner_finished,
  output logic                all_finished,
  output logic                none_eligible
);

  localparam int IDX_W  = THREADS > 1 ? $clog2(THREADS) : 1;
  localparam int SUM_W  = TICKET_BITS + CFG_W;
  localparam int WORD_W = TICKET_BITS + PROG_W;

  function automatic logic [IDX_W-1:0] to_addr(input logic [CFG_W-1:0] v);
    logic [IDX_W+CFG_W-1:0] w;
    w = {{IDX_W{1'b0}}, v};
    return w[IDX_W-1:0];
  endfunction

  state_t              state, state_next;
  logic [CFG_W-1:0]    active_threads;
  logic [CFG_W-1:0]    n_act;
  logic [CFG_W-1:0]    idx, idx_next;
  logic [SUM_W-1:0]    total, total_next;
  logic [SUM_W-1:0]    scan_sum, scan_sum_next;
  logic [SUM_W-1:0]    sum_add;
  logic [RAND_W-1:0]   rand_word, rand_word_next;
  logic [THREADS-1:0]  ent_valid;
  logic [THREADS-1:0]  ent_done;
  logic                rd_ok;
  logic [TICKET_BITS-1:0] rd_tick;
  logic [PROG_W-1:0]   rd_prog;
  logic [PROG_W-1:0]   prog_add;

  logic [TIDX_W-1:0]   res_win, res_win_next;
  logic [PROG_W-1:0]   res_prog, res_prog_next;
  logic                res_fin, res_fin_next;
  logic                res_none, res_none_next;
  logic                all_fin;
  logic                out_load;
  logic                out_valid_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_rem;

  logic [TICKET_BITS+TCOUNT_W-1:0] tick_ext;
  logic [IDX_W+TIDX_W-1:0]         tidx_ext;

  lts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (THREADS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lts_mod #(
    .SUM_W (SUM_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rand_word),
    .divisor  (total),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign n_act    = (32'(active_threads) > THREADS) ? CFG_W'(THREADS) : active_threads;
  assign in_stall = (state != ST_IDLE);
  assign rd_tick  = rd_ok ? ram_rdata[WORD_W-1:PROG_W] : '0;
  assign rd_prog  = rd_ok ? ram_rdata[PROG_W-1:0] : '0;
  assign sum_add  = scan_sum + SUM_W'(rd_tick);
  assign prog_add = rd_prog + PROGRESS_STEP;
  assign tick_ext = {{TICKET_BITS{1'b0}}, ticket_count};
  assign tidx_ext = {{IDX_W{1'b0}}, thread_index};

  always_comb begin
    all_fin = 1'b1;
    for (int i = 0; i < THREADS; i++) begin
      if (i < 32'(n_act) && !ent_done[i]) begin
        all_fin = 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    total_next     = total;
    scan_sum_next  = scan_sum;
    rand_word_next = rand_word;
    res_win_next   = res_win;
    res_prog_next  = res_prog;
    res_fin_next   = res_fin;
    res_none_next  = res_none;
    ram_we         = 1'b0;
    ram_waddr      = to_addr(idx);
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = to_addr(idx);
    div_start      = 1'b0;
    out_load       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          res_win_next  = '0;
          res_prog_next = '0;
          res_fin_next  = 1'b0;
          res_none_next = 1'b0;
          if (kind == KIND_DRAW) begin
            rand_word_next = random_value;
            idx_next       = '0;
            total_next     = '0;
            state_next     = ST_SUM_RD;
          end else begin
            if (32'(thread_index) < THREADS) begin
              ram_we    = 1'b1;
              ram_waddr = tidx_ext[IDX_W-1:0];
              ram_wdata = {tick_ext[TICKET_BITS-1:0], {PROG_W{1'b0}}};
            end
            state_next = ST_RESULT;
          end
        end
      end
      ST_SUM_RD: begin
        if (idx == n_act) begin
          if (total == '0) begin
            res_none_next = 1'b1;
            state_next    = ST_RESULT;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end else begin
          ram_re     = 1'b1;
          state_next = ST_SUM_ACC;
        end
      end
      ST_SUM_ACC: begin
        total_next = total + SUM_W'(rd_tick);
        idx_next   = idx + 1'b1;
        state_next = ST_SUM_RD;
      end
      ST_DIV: begin
        if (div_done) begin
          idx_next      = '0;
          scan_sum_next = '0;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        ram_re     = 1'b1;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (sum_add > div_rem) begin
          res_win_next = idx[TIDX_W-1:0];
          ram_we       = 1'b1;
          if (prog_add >= PROGRESS_DONE) begin
            res_prog_next = PROGRESS_DONE;
            res_fin_next  = 1'b1;
            ram_wdata     = {{TICKET_BITS{1'b0}}, PROGRESS_DONE};
          end else begin
            res_prog_next = prog_add;
            ram_wdata     = {rd_tick, prog_add};
          end
          state_next = ST_RESULT;
        end else begin
          scan_sum_next = sum_add;
          idx_next      = idx + 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_RESULT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      active_threads <= ACTIVE_RESET;
      ent_valid      <= '0;
      ent_done       <= '0;
      rd_ok          <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        active_threads <= cfg_wr_data;
      end
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
        ent_done[ram_waddr]  <= (ram_wdata[PROG_W-1:0] == PROGRESS_DONE);
      end
      if (ram_re) begin
        rd_ok <= ent_valid[ram_raddr];
      end
    end
    idx       <= idx_next;
    total     <= total_next;
    scan_sum  <= scan_sum_next;
    rand_word <= rand_word_next;
    res_win   <= res_win_next;
    res_prog  <= res_prog_next;
    res_fin   <= res_fin_next;
    res_none  <= res_none_next;
    if (out_load) begin
      winner_index    <= res_win;
      winner_progress <= res_prog;
      winner_finished <= res_fin;
      none_eligible   <= res_none;
      all_finished    <= all_fin;
    end
  end

endmodule

// ----- bench/lts_checker.sv -----
`timescale 1ns / 100ps
// lottery scheduler checker: watches config, input and result channels, predicts each result
// beat from its own ticket/progress tables and compares it field by field
// uses lts_pkg
module lts_checker
  import lts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                kind,
  input  logic [TIDX_W-1:0]   thread_index,
  input  logic [TCOUNT_W-1:0] ticket_count,
  input  logic [RAND_W-1:0]   random_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [TIDX_W-1:0]   winner_index,
  input  logic [PROG_W-1:0]   winner_progress,
  input  logic                winner_finished,
  input  logic                all_finished,
  input  logic                none_eligible,
  output int                  outstanding,
  output int                  errors
);

  typedef struct packed {
    logic [TIDX_W-1:0] win;
    logic [PROG_W-1:0] prog;
    logic              fin;
    logic              all_fin;
    logic              none;
  } outcome_t;

  logic [TCOUNT_W-1:0] tickets  [THREADS_DEF];
  logic [PROG_W-1:0]   progress [THREADS_DEF];
  logic [CFG_W-1:0]    active_cfg;
  outcome_t            outcomes_due [$];
  int                  err_cnt = 0;

  function automatic int live_threads();
    return (active_cfg > THREADS_DEF) ? THREADS_DEF : int'(active_cfg);
  endfunction

  function automatic logic every_thread_done();
    for (int i = 0; i < live_threads(); i++) begin
      if (progress[i] < PROGRESS_DONE) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic outcome_t schedule_step(logic item_kind, logic [TIDX_W-1:0] idx,
                                             logic [TCOUNT_W-1:0] cnt,
                                             logic [RAND_W-1:0] rnd);
    outcome_t    o;
    logic [63:0] total;
    logic [63:0] run;
    logic [63:0] pick;
    logic [7:0]  next_prog;
    int          n;
    o     = '0;
    total = '0;
    run   = '0;
    n     = live_threads();
    if (item_kind == KIND_LOAD) begin
      if (idx < THREADS_DEF) begin
        tickets[idx]  = cnt;
        progress[idx] = '0;
      end
    end else begin
      for (int i = 0; i < n; i++) total += tickets[i];
      if (total == 0) begin
        o.none = 1'b1;
      end else begin
        pick = (64'(rnd) % total) + 64'd1;
        for (int i = 0; i < n; i++) begin
          run += tickets[i];
          if (run >= pick) begin
            o.win = TIDX_W'(i);
            break;
          end
        end
        next_prog = 8'(progress[o.win]) + 8'(PROGRESS_STEP);
        if (next_prog >= 8'(PROGRESS_DONE)) begin
          o.prog         = PROGRESS_DONE;
          o.fin          = 1'b1;
          tickets[o.win] = '0;
        end else begin
          o.prog = PROG_W'(next_prog);
        end
        progress[o.win] = o.prog;
      end
    end
    o.all_fin = every_thread_done();
    return o;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      for (int i = 0; i < THREADS_DEF; i++) begin
        tickets[i]  = '0;
        progress[i] = '0;
      end
      active_cfg = ACTIVE_RESET;
      outcomes_due.delete();
    end else begin
      if (cfg_wr_en) active_cfg = cfg_wr_data;
      if (in_valid && !in_stall)
        outcomes_due.push_back(schedule_step(kind, thread_index, ticket_count, random_value));
      if (out_valid && !out_stall) begin
        if (outcomes_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          err_cnt++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("winner_index", 32'(want.win), 32'(winner_index));
          check_field("winner_progress", 32'(want.prog), 32'(winner_progress));
          check_field("winner_finished", 32'(want.fin), 32'(winner_finished));
          check_field("all_finished", 32'(want.all_fin), 32'(all_finished));
          check_field("none_eligible", 32'(want.none), 32'(none_eligible));
        end
      end
    end
    outstanding <= outcomes_due.size();
    errors      <= err_cnt;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// lottery scheduler bench top: clock, reset, load/draw stimulus with random gaps and stalls
// uses lts_pkg, lottery_thread_scheduler_top and lts_checker
module tb;
  import lts_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 120;
  localparam int RANDOM_BEATS = 900;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic                kind;
  logic [TIDX_W-1:0]   thread_index;
  logic [TCOUNT_W-1:0] ticket_count;
  logic [RAND_W-1:0]   random_value;
  logic                out_valid;
  logic                out_stall;
  logic [TIDX_W-1:0]   winner_index;
  logic [PROG_W-1:0]   winner_progress;
  logic                winner_finished;
  logic                all_finished;
  logic                none_eligible;

  int outstanding;
  int errors;
  int beats_sent;
  int draws_sent;
  int settings_used;
  int active_now;
  int idle_cycles;
  int stall_left;
  bit calm;

  lottery_thread_scheduler_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .thread_index    (thread_index),
    .ticket_count    (ticket_count),
    .random_value    (random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .winner_index    (winner_index),
    .winner_progress (winner_progress),
    .winner_finished (winner_finished),
    .all_finished    (all_finished),
    .none_eligible   (none_eligible)
  );

  lts_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .thread_index    (thread_index),
    .ticket_count    (ticket_count),
    .random_value    (random_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .winner_index    (winner_index),
    .winner_progress (winner_progress),
    .winner_finished (winner_finished),
    .all_finished    (all_finished),
    .none_eligible   (none_eligible),
    .outstanding     (outstanding),
    .errors          (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [TCOUNT_W-1:0] pick_tickets();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return TCOUNT_W'($urandom_range(1, 15));
      default: return TCOUNT_W'($urandom());
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] pick_random();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TIDX_W-1:0] pick_thread();
    if (active_now == 0 || active_now > THREADS_DEF || $urandom_range(0, 3) == 0)
      return TIDX_W'($urandom());
    return TIDX_W'($urandom_range(0, active_now - 1));
  endfunction

  task automatic send_beat(logic item_kind, logic [TIDX_W-1:0] idx,
                           logic [TCOUNT_W-1:0] cnt, logic [RAND_W-1:0] rnd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= item_kind;
    thread_index <= idx;
    ticket_count <= cnt;
    random_value <= rnd;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (item_kind == KIND_DRAW) draws_sent++;
  endtask

  task automatic load_thread(logic [TIDX_W-1:0] idx, logic [TCOUNT_W-1:0] cnt);
    send_beat(KIND_LOAD, idx, cnt, $urandom());
  endtask

  task automatic draw_once(logic [RAND_W-1:0] rnd);
    send_beat(KIND_DRAW, TIDX_W'($urandom()), TCOUNT_W'($urandom()), rnd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_active(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_now  = int'(value);
    settings_used++;
  endtask

  // result side stall, drawn per result beat
  initial begin
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        stall_left = draw_gap();
        if (stall_left > 0) out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lottery_thread_scheduler_top: mismatch");
    $finish;
  end

  initial begin
    int rand_beats;
    int phase_end;
    int nloads;
    int ndraws;
    int phase;
    logic [CFG_W-1:0] setting;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    kind         <= KIND_LOAD;
    thread_index <= '0;
    ticket_count <= '0;
    random_value <= '0;
    calm          = 1'b0;
    beats_sent    = 0;
    draws_sent    = 0;
    settings_used = 0;
    active_now    = int'(ACTIVE_RESET);
    rand_beats    = 0;
    phase         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty tables at the reset thread count
    draw_once('0);
    load_thread(3'd0, 16'hFFFF);
    load_thread(3'd7, 16'd1);
    load_thread(3'd3, 16'd0);
    draw_once('1);
    // thread 0 runs to the progress cap and loses its tickets
    repeat (5) draw_once('0);
    repeat (4) draw_once('1);
    // every ticket gone
    draw_once($urandom());
    load_thread(3'd7, 16'd5);
    load_thread(3'd2, 16'hA5A5);
    load_thread(3'd5, 16'h5A5A);
    draw_once(32'h8000_0000);
    draw_once(32'h7FFF_FFFF);

    // single thread until all finished
    set_active(4'd1);
    load_thread(3'd0, 16'd3);
    repeat (5) draw_once($urandom());
    draw_once($urandom());
    // no thread active
    set_active(4'd0);
    draw_once($urandom());
    load_thread(3'd4, 16'd9);

    while (rand_beats < RANDOM_BEATS) begin
      case (phase)
        0:       setting = 4'd15;
        1:       setting = 4'd8;
        2:       setting = 4'd1;
        3:       setting = 4'd2;
        4:       setting = 4'd0;
        5:       setting = 4'd9;
        default: setting = CFG_W'($urandom_range(0, 15));
      endcase
      set_active(setting);
      phase++;
      calm      = ($urandom_range(0, 3) == 0);
      phase_end = rand_beats + $urandom_range(50, 90);
      while (rand_beats < phase_end) begin
        if ($urandom_range(0, 7) == 0) begin
          send_beat(1'($urandom()), TIDX_W'($urandom()), pick_tickets(), $urandom());
          rand_beats++;
        end else begin
          nloads = $urandom_range(1, 8);
          ndraws = $urandom_range(4, 24);
          repeat (nloads) load_thread(pick_thread(), pick_tickets());
          repeat (ndraws) draw_once(pick_random());
          rand_beats += nloads + ndraws;
        end
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d beats, %0d of them draws, across %0d thread-count settings",
             beats_sent, draws_sent, settings_used);
    if (errors == 0 && outstanding == 0) begin
      $display("lottery_thread_scheduler_top: match");
    end else begin
      $display("lottery_thread_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lts_pkg.sv
rtl/lts_ram.sv
rtl/lts_mod.sv
rtl/lottery_thread_scheduler_top.sv
bench/lts_checker.sv
bench/tb.sv
